@@ src/sust_pkg.sv @@
// Shared types and constants for the sorted unique set table.
// No dependencies; imported by the controller, the datapath and the top level.
package sust_pkg;

	localparam int KEY_W = 32;
	localparam int OCC_W = 5;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_SEARCH = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_DUP      = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHIFT,
		S_PUT,
		S_RESULT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic    load;        // latch request, arm the scan
		logic    scan_step;
		logic    shift_start;
		logic    shift_step;
		logic    put;         // write key at its sorted position, count up
		logic    cnt_clear;
		logic    cnt_dec;
		logic    set_res;
		status_t res_status;
		logic    out_load;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		mode_t mode;
		logic  hit;        // compared entry is not below the key
		logic  scan_end;   // all entries below the key
		logic  found;
		logic  full;
		logic  shift_end;
		logic  out_free;
	} dp_stat_t;

endpackage

@@ src/sust_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sust_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/sust_ctrl.sv @@
// Sequencing state machine for the sorted set table.
// Depends on sust_pkg; drives the datapath through dp_cmd_t, watches dp_stat_t.
module sust_ctrl
	import sust_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.mode == MODE_CLEAR) begin
					cmd.cnt_clear  = 1'b1;
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_DONE;
					state_d        = S_RESULT;
				end else begin
					cmd.scan_step = 1'b1;
					if (stat.hit || stat.scan_end) begin
						state_d = S_DECIDE;
					end
				end
			end
			S_DECIDE: begin
				cmd.set_res = 1'b1;
				state_d     = S_RESULT;
				case (stat.mode)
					MODE_INSERT: begin
						if (stat.found) begin
							cmd.res_status = ST_DUP;
						end else if (stat.full) begin
							cmd.res_status = ST_FULL;
						end else begin
							cmd.res_status  = ST_DONE;
							cmd.shift_start = 1'b1;
							state_d         = S_SHIFT;
						end
					end
					MODE_REMOVE: begin
						if (!stat.found) begin
							cmd.res_status = ST_NOTFOUND;
						end else begin
							cmd.res_status  = ST_DONE;
							cmd.shift_start = 1'b1;
							state_d         = S_SHIFT;
						end
					end
					default: begin
						cmd.res_status = stat.found ? ST_DONE : ST_NOTFOUND;
					end
				endcase
			end
			S_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (stat.shift_end) begin
					if (stat.mode == MODE_INSERT) begin
						state_d = S_PUT;
					end else begin
						cmd.cnt_dec = 1'b1;
						state_d     = S_RESULT;
					end
				end
			end
			S_PUT: begin
				cmd.put = 1'b1;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ src/sust_dp.sv @@
// Datapath of the sorted set table: store, count, scan and shift pointers, result register.
// Depends on sust_pkg and sust_ram.
module sust_dp
	import sust_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_stat_t         stat,
	input  logic [1:0]       in_mode,
	input  logic [KEY_W-1:0] in_key,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_data
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	mode_t            mode_q;
	logic [KEY_W-1:0] key_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    rem_q;
	logic [CW-1:0]    pos_q;
	logic [CW-1:0]    wdst_q;
	logic             chk_q;
	logic             wpend_q;
	logic             found_q;
	status_t          res_q;
	logic             out_valid_q;
	logic [7:0]       out_data_q;

	logic             we;
	logic [AW-1:0]    waddr;
	logic [KEY_W-1:0] wdata;
	logic [KEY_W-1:0] rdata;
	logic             issue;
	logic             hit;
	logic             scan_end;
	logic             sh_issue;
	logic             up;
	logic [CW+4:0]    occ_ext;

	sust_ram #(
		.WIDTH(KEY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(idx_q[AW-1:0]),
		.rdata(rdata)
	);

	// scan: one read issued per cycle, the previous read compared
	assign issue    = idx_q < cnt_q;
	assign hit      = chk_q && ($signed(rdata) >= $signed(key_q));
	assign scan_end = !hit && !issue;

	// shift: insert moves entries up from the top, remove moves them down
	assign up       = (mode_q == MODE_INSERT);
	assign sh_issue = (rem_q != '0);

	assign we    = cmd.put || (cmd.shift_step && wpend_q);
	assign waddr = cmd.put ? pos_q[AW-1:0] : wdst_q[AW-1:0];
	assign wdata = cmd.put ? key_q : rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			chk_q       <= 1'b0;
			wpend_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				chk_q <= 1'b0;
			end else if (cmd.scan_step && !hit && !scan_end) begin
				chk_q <= issue;
			end

			if (cmd.shift_start) begin
				wpend_q <= 1'b0;
			end else if (cmd.shift_step) begin
				wpend_q <= sh_issue;
			end

			if (cmd.cnt_clear) begin
				cnt_q <= '0;
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end else if (cmd.put) begin
				cnt_q <= cnt_q + CW'(1);
			end

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode_t'(in_mode);
			key_q  <= in_key;
			idx_q  <= '0;
		end else if (cmd.scan_step) begin
			if (hit) begin
				pos_q   <= idx_q - CW'(1);
				found_q <= (rdata == key_q);
			end else if (scan_end) begin
				pos_q   <= cnt_q;
				found_q <= 1'b0;
			end else if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
		end else if (cmd.shift_start) begin
			if (up) begin
				idx_q <= cnt_q - CW'(1);
				rem_q <= cnt_q - pos_q;
			end else begin
				idx_q <= pos_q + CW'(1);
				rem_q <= cnt_q - pos_q - CW'(1);
			end
		end else if (cmd.shift_step && sh_issue) begin
			idx_q  <= up ? idx_q - CW'(1) : idx_q + CW'(1);
			wdst_q <= up ? idx_q + CW'(1) : idx_q - CW'(1);
			rem_q  <= rem_q - CW'(1);
		end

		if (cmd.set_res) begin
			res_q <= cmd.res_status;
		end

		if (cmd.out_load) begin
			out_data_q <= {occ_ext[OCC_W-1:0], (mode_q != MODE_CLEAR) && found_q, res_q};
		end
	end

	// occupancy carries the low five bits of the count
	assign occ_ext = {5'd0, cnt_q};

	assign stat.mode      = mode_q;
	assign stat.hit       = hit;
	assign stat.scan_end  = scan_end;
	assign stat.found     = found_q;
	assign stat.full      = (cnt_q == CW'(CAPACITY));
	assign stat.shift_end = !sh_issue && !wpend_q;
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ src/sorted_unique_set_table.sv @@
// Sorted unique set table: ascending store of distinct signed 32-bit keys.
// Search, insert and remove make a linear scan; an insert or remove that changes the set then
// does a one-entry-per-cycle shift through the single RAM write port.
// Throughput: one request at a time; next request taken as soon as the result is registered.
// Reset (arst_n low, asynchronous): set empty, no result pending; store contents left as is.
module sorted_unique_set_table
	import sust_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] key (signed)
	input  logic [1:0]  s_axis_tuser,  // [1:0] mode: insert, remove, search, clear
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata   // [1:0] status, [2] found, [7:3] occupancy
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Controller walks: accept -> scan -> decide -> shift -> put -> result; others skip some.
	sust_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// Datapath holds the sorted RAM, entry count and the output item register,
	// so a finished result can wait on the master side while a new item is taken.
	sust_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_mode  (s_axis_tuser),
		.in_key   (s_axis_tdata),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata)
	);

endmodule

@@ test/sorted_unique_set_table_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sorted_unique_set_table.
// Depends on sust_pkg and the block itself; keeps a shadow copy of the sorted set to predict results.
module sorted_unique_set_table_test;
	import sust_pkg::*;

	localparam int          CAPACITY    = 16;
	localparam int unsigned CYCLE_LIMIT = 400000;
	// settle time after the last result
	localparam int unsigned SETTLE_CYCLES = 64;
	localparam int unsigned POOL_SIZE     = 24;

	// one result item as it sits in m_axis_tdata: [1:0] status, [2] found, [7:3] occupancy
	typedef struct packed {
		logic [4:0] occupancy;
		logic       found;
		status_t    status;
	} set_result_t;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        s_axis_tvalid  = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata   = '0;
	logic [1:0]  s_axis_tuser   = MODE_CLEAR;
	logic        m_axis_tvalid;
	logic        m_axis_tready  = 1'b0;
	logic [7:0]  m_axis_tdata;

	// shadow of the block's store and count
	logic signed [31:0] shadow_keys [CAPACITY];
	int unsigned        shadow_count = 0;

	set_result_t pending_results [$];
	logic [31:0] key_pool [POOL_SIZE];

	int unsigned src_idle_pct  = 27;
	int unsigned sink_idle_pct = 27;
	int unsigned sink_hold_len = 0;   // picked up and counted down by the receiver
	int unsigned cycle_count   = 0;
	int unsigned fail_count    = 0;
	int unsigned items_sent    = 0;
	int unsigned results_seen  = 0;
	int unsigned status_seen [4] = '{0, 0, 0, 0};
	int unsigned mode_sent   [4] = '{0, 0, 0, 0};

	sorted_unique_set_table #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Apply one request to the shadow set and return the result the block must give.
	function automatic set_result_t predict_set_result(mode_t mode, logic signed [31:0] key);
		set_result_t res;
		int unsigned pos;
		int unsigned i;
		logic        hit;
		res.status = ST_DONE;
		res.found  = 1'b0;
		if (mode == MODE_CLEAR) begin
			// found stays 0: nothing is looked up
			shadow_count = 0;
		end else begin
			pos = 0;
			while (pos < shadow_count && shadow_keys[pos] < key)
				pos++;
			hit       = (pos < shadow_count) && (shadow_keys[pos] == key);
			res.found = hit;
			if (mode == MODE_INSERT) begin
				if (hit) begin
					res.status = ST_DUP;
				end else if (shadow_count >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					for (i = shadow_count; i > pos; i--)
						shadow_keys[i] = shadow_keys[i - 1];
					shadow_keys[pos] = key;
					shadow_count++;
				end
			end else if (!hit) begin
				res.status = ST_NOTFOUND;
			end else if (mode == MODE_REMOVE) begin
				for (i = pos; i + 1 < shadow_count; i++)
					shadow_keys[i] = shadow_keys[i + 1];
				shadow_count--;
			end
		end
		res.occupancy = 5'(shadow_count);
		return res;
	endfunction

	// Offer one request; returns at the edge that accepted it, with tvalid still high so
	// a back-to-back item can follow in the same step.
	task automatic send_request(mode_t mode, logic [31:0] key);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= key;
		s_axis_tuser  <= mode;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_results.push_back(predict_set_result(mode, key));
		items_sent++;
		mode_sent[int'(mode)]++;
	endtask

	// Stop offering and wait until every expected result has been checked.
	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic mode_t pick_mode(int unsigned ins_w, int unsigned rem_w,
	                                    int unsigned srch_w);
		int unsigned r;
		r = $urandom_range(99);
		if (r < ins_w)
			return MODE_INSERT;
		if (r < ins_w + rem_w)
			return MODE_REMOVE;
		if (r < ins_w + rem_w + srch_w)
			return MODE_SEARCH;
		return MODE_CLEAR;
	endfunction

	// Mostly keys from a small pool, so hits, duplicates and a full store come often;
	// the rest are free 32-bit values.
	function automatic logic [31:0] pick_key();
		if ($urandom_range(99) < 85)
			return key_pool[$urandom_range(POOL_SIZE - 1)];
		return $urandom;
	endfunction

	task automatic refresh_key_pool();
		int unsigned i;
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7fff_ffff;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hffff_ffff;
		for (i = 4; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
	endtask

	task automatic run_random_round(int unsigned count, int unsigned ins_w,
	                                int unsigned rem_w, int unsigned srch_w);
		int unsigned n;
		refresh_key_pool();
		for (n = 0; n < count; n++)
			send_request(pick_mode(ins_w, rem_w, srch_w), pick_key());
	endtask

	// Extremes, every operation, duplicate, misses, filling to capacity and a refused insert.
	task automatic test_directed();
		int unsigned j;
		send_request(MODE_CLEAR,  $urandom);
		send_request(MODE_INSERT, 32'h7fff_ffff);
		send_request(MODE_INSERT, 32'h8000_0000);
		send_request(MODE_INSERT, 32'h0000_0000);
		send_request(MODE_INSERT, 32'h0000_0000);   // duplicate ignored
		send_request(MODE_SEARCH, 32'h8000_0000);
		send_request(MODE_SEARCH, 32'd5);           // miss
		send_request(MODE_REMOVE, 32'd5);           // miss
		send_request(MODE_REMOVE, 32'h8000_0000);   // head of the list
		send_request(MODE_SEARCH, 32'h7fff_ffff);
		// fill up: alternating positive and negative keys land all over the array
		for (j = 0; j < CAPACITY - 2; j++)
			send_request(MODE_INSERT, (j % 2) ? -(j * 1000) : (j + 1) * 1000);
		send_request(MODE_INSERT, 32'd12345);       // full, refused
		send_request(MODE_INSERT, 32'h0000_0000);   // present key while full: duplicate
		send_request(MODE_REMOVE, 32'h7fff_ffff);   // tail of the list
		send_request(MODE_CLEAR,  $urandom);
	endtask

	task automatic test_random_mix();
		run_random_round(300, 45, 25, 27);   // balanced
		run_random_round(250, 70, 10, 17);   // insert heavy, reaches full often
		run_random_round(250, 25, 50, 22);   // remove heavy, drains towards empty
	endtask

	task automatic test_no_idle_stretch();
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		run_random_round(200, 45, 25, 27);
		src_idle_pct  = 27;
		sink_idle_pct = 27;
	endtask

	// Receiver stops for a long while; the sender keeps offering and must be stalled.
	task automatic test_output_hold_off();
		sink_hold_len = 400;
		run_random_round(30, 50, 20, 27);
	endtask

	// Sender pauses until the block has handed back every result, then carries on.
	task automatic test_sender_pause();
		run_random_round(12, 50, 20, 27);
		wait_results_drained();
		run_random_round(12, 50, 20, 27);
	endtask

	// Receiver: checks each accepted result against the oldest expectation and
	// drives tready, with random idling or a counted hold-off.
	initial begin
		set_result_t got;
		set_result_t want;
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				got = set_result_t'(m_axis_tdata);
				results_seen++;
				if (pending_results.size() == 0) begin
					$display("%0t: result with none expected, tdata %h", $time, m_axis_tdata);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					status_seen[int'(want.status)]++;
					if (got.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, got.status);
						fail_count++;
					end
					if (got.found !== want.found) begin
						$display("%0t: found expected %0d actual %0d", $time,
							want.found, got.found);
						fail_count++;
					end
					if (got.occupancy !== want.occupancy) begin
						$display("%0t: occupancy expected %0d actual %0d", $time,
							want.occupancy, got.occupancy);
						fail_count++;
					end
				end
			end
			if (sink_hold_len != 0) begin
				hold_left     = sink_hold_len;
				sink_hold_len = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			pending_results.size());
		$display("sorted_unique_set_table_test: done, errors");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_mix();
		test_no_idle_stretch();
		test_output_hold_off();
		test_sender_pause();

		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d requests (insert %0d, remove %0d, search %0d, clear %0d), %0d results",
			items_sent, mode_sent[MODE_INSERT], mode_sent[MODE_REMOVE],
			mode_sent[MODE_SEARCH], mode_sent[MODE_CLEAR], results_seen);
		$display("outcomes: done %0d, duplicate %0d, miss %0d, full refused %0d; %0d cycles",
			status_seen[ST_DONE], status_seen[ST_DUP], status_seen[ST_NOTFOUND],
			status_seen[ST_FULL], cycle_count);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("sorted_unique_set_table_test: done, clean");
		end else begin
			$display("sorted_unique_set_table_test: done, errors");
		end
		$finish;
	end

endmodule

@@ sorted_unique_set_table.f @@
src/sust_pkg.sv
src/sust_ram.sv
src/sust_ctrl.sv
src/sust_dp.sv
src/sorted_unique_set_table.sv
test/sorted_unique_set_table_test.sv
